FILE: hw/rtl/ptp_pkg.sv
// Shared types and constants for the properties text parser.
package ptp_pkg;

  // Parser phase, one-hot coded.
  typedef enum logic [7:0] {
    PH_LINE_START = 8'b0000_0001,
    PH_COMMENT    = 8'b0000_0010,
    PH_KEY        = 8'b0000_0100,
    PH_SEP_WS     = 8'b0000_1000,
    PH_VALUE_WS   = 8'b0001_0000,
    PH_VALUE      = 8'b0010_0000,
    PH_CONT_SKIP  = 8'b0100_0000,
    PH_LINE_CONT  = 8'b1000_0000
  } phase_e;

  // Result kinds.
  typedef enum logic [2:0] {
    KIND_KEY   = 3'd0,
    KIND_VALUE = 3'd1,
    KIND_END   = 3'd2,
    KIND_ERROR = 3'd3,
    KIND_EMPTY = 3'd4
  } kind_e;

  // Parser state carried from one character to the next.
  typedef struct packed {
    phase_e      phase;
    logic        esc;
    logic [2:0]  hex_cnt;
    logic [15:0] hex_acc;
    logic        fiv;
    logic        cr;
    logic        err;
  } state_t;

  // One result request.
  typedef struct packed {
    kind_e       kind;
    logic [15:0] ch;
    logic        done;
  } result_t;

  localparam state_t STATE_RESET = '{
    phase:   PH_LINE_START,
    esc:     1'b0,
    hex_cnt: 3'd0,
    hex_acc: 16'd0,
    fiv:     1'b0,
    cr:      1'b0,
    err:     1'b0
  };

  // Characters with a special meaning.
  localparam logic [15:0] CH_TAB   = 16'h0009;
  localparam logic [15:0] CH_LF    = 16'h000A;
  localparam logic [15:0] CH_FF    = 16'h000C;
  localparam logic [15:0] CH_CR    = 16'h000D;
  localparam logic [15:0] CH_SPACE = 16'h0020;
  localparam logic [15:0] CH_BANG  = 16'h0021;
  localparam logic [15:0] CH_HASH  = 16'h0023;
  localparam logic [15:0] CH_COLON = 16'h003A;
  localparam logic [15:0] CH_EQ    = 16'h003D;
  localparam logic [15:0] CH_BSL   = 16'h005C;
  localparam logic [15:0] CH_LC_F  = 16'h0066;
  localparam logic [15:0] CH_LC_N  = 16'h006E;
  localparam logic [15:0] CH_LC_R  = 16'h0072;
  localparam logic [15:0] CH_LC_T  = 16'h0074;
  localparam logic [15:0] CH_LC_U  = 16'h0075;

endpackage

FILE: hw/rtl/ptp_if.sv
// Handshake channel interfaces for the text input and the result output.
interface ptp_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] char_in;
  logic        text_end;

  modport source (output valid, output char_in, output text_end, input ready);
  modport sink (input valid, input char_in, input text_end, output ready);
endinterface

interface ptp_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [15:0] char_out;
  logic        text_done;

  modport source (output valid, output kind, output char_out, output text_done, input ready);
  modport sink (input valid, input kind, input char_out, input text_done, output ready);
endinterface

FILE: hw/rtl/ptp_step.sv
// Next-state and result logic for one character of properties text.
module ptp_step (
  input  ptp_pkg::state_t  st_i,
  input  logic [15:0]      char_i,
  input  logic             text_end_i,
  output ptp_pkg::state_t  st_o,
  output logic             res_valid_o,
  output ptp_pkg::result_t res_o
);
  import ptp_pkg::*;

  function automatic logic is_ws(input logic [15:0] c);
    return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_FF);
  endfunction

  function automatic logic is_sep(input logic [15:0] c);
    return (c == CH_EQ) || (c == CH_COLON);
  endfunction

  // Returns a valid flag above the digit value.
  function automatic logic [4:0] hex_digit(input logic [15:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c inside {[16'h0030:16'h0039]}) begin
      r = {1'b1, 4'(c - 16'h0030)};
    end else if (c inside {[16'h0061:16'h0066]}) begin
      r = {1'b1, 4'(c - 16'h0057)};
    end else if (c inside {[16'h0041:16'h0046]}) begin
      r = {1'b1, 4'(c - 16'h0037)};
    end
    return r;
  endfunction

  logic        nl;
  logic        lf_drop;
  logic [4:0]  hd;
  phase_e      ph;
  logic [15:0] esc_ch;

  always_comb begin
    st_o        = st_i;
    res_valid_o = 1'b0;
    res_o       = '{kind: KIND_KEY, ch: 16'd0, done: 1'b0};
    nl          = (char_i == CH_CR) || (char_i == CH_LF);
    lf_drop     = st_i.cr && (char_i == CH_LF);
    hd          = hex_digit(char_i);
    ph          = st_i.phase;
    esc_ch      = char_i;

    if (text_end_i) begin
      // End of text: close out and return to the reset state.
      st_o        = STATE_RESET;
      res_valid_o = 1'b1;
      res_o.done  = 1'b1;
      if (st_i.err || (st_i.hex_cnt != 3'd0)) begin
        res_o.kind = KIND_ERROR;
      end else if (st_i.phase inside {PH_KEY, PH_SEP_WS, PH_VALUE_WS, PH_VALUE,
                                      PH_CONT_SKIP}) begin
        res_o.kind = KIND_END;
      end else begin
        res_o.kind = KIND_EMPTY;
      end
    end else if (!st_i.err) begin
      st_o.cr = 1'b0;
      if (!lf_drop) begin
        if (char_i == CH_CR) begin
          st_o.cr = 1'b1;
        end

        if (st_i.esc) begin
          // Character after a backslash.
          st_o.esc = 1'b0;
          if (nl) begin
            if (st_i.phase inside {PH_KEY, PH_VALUE}) begin
              st_o.phase = PH_CONT_SKIP;
            end else if (st_i.phase == PH_LINE_START) begin
              st_o.phase = PH_LINE_CONT;
            end
          end else if (st_i.hex_cnt != 3'd0) begin
            st_o.err     = 1'b1;
            st_o.hex_cnt = 3'd0;
            res_valid_o  = 1'b1;
            res_o.kind   = KIND_ERROR;
          end else begin
            if (st_i.phase inside {PH_SEP_WS, PH_VALUE_WS, PH_VALUE}) begin
              st_o.phase = PH_VALUE;
              st_o.fiv   = 1'b1;
            end else begin
              st_o.phase = PH_KEY;
              st_o.fiv   = 1'b0;
            end
            case (char_i)
              CH_LC_T: esc_ch = CH_TAB;
              CH_LC_N: esc_ch = CH_LF;
              CH_LC_R: esc_ch = CH_CR;
              CH_LC_F: esc_ch = CH_FF;
              default: esc_ch = char_i;
            endcase
            if (char_i == CH_LC_U) begin
              st_o.hex_cnt = 3'd4;
              st_o.hex_acc = 16'd0;
            end else begin
              res_valid_o = 1'b1;
              res_o.kind  = st_o.fiv ? KIND_VALUE : KIND_KEY;
              res_o.ch    = esc_ch;
            end
          end
        end else if (st_i.phase == PH_COMMENT) begin
          // Comment text runs to the line end.
          if (nl) begin
            st_o.phase = PH_LINE_START;
          end
        end else if (!((st_i.phase == PH_CONT_SKIP) && !nl && is_ws(char_i))) begin
          // Leaving the leading blanks of a continuation line.
          if ((st_i.phase == PH_CONT_SKIP) && !nl) begin
            ph = st_i.fiv ? PH_VALUE : PH_KEY;
          end
          st_o.phase = ph;

          if (nl) begin
            // Line end.
            if (st_i.hex_cnt != 3'd0) begin
              st_o.err     = 1'b1;
              st_o.hex_cnt = 3'd0;
              res_valid_o  = 1'b1;
              res_o.kind   = KIND_ERROR;
            end else if ((ph == PH_LINE_START) || (ph == PH_LINE_CONT)) begin
              st_o.phase = PH_LINE_START;
            end else begin
              st_o.phase  = PH_LINE_START;
              st_o.fiv    = 1'b0;
              res_valid_o = 1'b1;
              res_o.kind  = KIND_END;
            end
          end else if (st_i.hex_cnt != 3'd0) begin
            // Gathering the digits of a unicode escape.
            if (char_i == CH_BSL) begin
              st_o.esc = 1'b1;
            end else if (!hd[4]) begin
              st_o.err     = 1'b1;
              st_o.hex_cnt = 3'd0;
              res_valid_o  = 1'b1;
              res_o.kind   = KIND_ERROR;
            end else begin
              st_o.hex_acc = {st_i.hex_acc[11:0], hd[3:0]};
              st_o.hex_cnt = st_i.hex_cnt - 3'd1;
              if (st_i.hex_cnt == 3'd1) begin
                res_valid_o = 1'b1;
                res_o.kind  = st_i.fiv ? KIND_VALUE : KIND_KEY;
                res_o.ch    = st_o.hex_acc;
              end
            end
          end else if (char_i == CH_BSL) begin
            st_o.esc = 1'b1;
          end else begin
            // Plain character, by phase.
            case (ph)
              PH_LINE_START, PH_LINE_CONT: begin
                if (is_ws(char_i)) begin
                  st_o.phase = ph;
                end else if ((ph == PH_LINE_START) &&
                             ((char_i == CH_HASH) || (char_i == CH_BANG))) begin
                  st_o.phase = PH_COMMENT;
                end else if (is_sep(char_i)) begin
                  st_o.phase = PH_VALUE_WS;
                  st_o.fiv   = 1'b1;
                end else begin
                  st_o.phase  = PH_KEY;
                  st_o.fiv    = 1'b0;
                  res_valid_o = 1'b1;
                  res_o.kind  = KIND_KEY;
                  res_o.ch    = char_i;
                end
              end
              PH_KEY: begin
                if (is_sep(char_i)) begin
                  st_o.phase = PH_VALUE_WS;
                  st_o.fiv   = 1'b1;
                end else if (is_ws(char_i)) begin
                  st_o.phase = PH_SEP_WS;
                  st_o.fiv   = 1'b1;
                end else begin
                  res_valid_o = 1'b1;
                  res_o.kind  = st_i.fiv ? KIND_VALUE : KIND_KEY;
                  res_o.ch    = char_i;
                end
              end
              PH_SEP_WS: begin
                if (is_sep(char_i)) begin
                  st_o.phase = PH_VALUE_WS;
                end else if (!is_ws(char_i)) begin
                  st_o.phase  = PH_VALUE;
                  st_o.fiv    = 1'b1;
                  res_valid_o = 1'b1;
                  res_o.kind  = KIND_VALUE;
                  res_o.ch    = char_i;
                end
              end
              PH_VALUE_WS: begin
                if (!is_ws(char_i)) begin
                  st_o.phase  = PH_VALUE;
                  st_o.fiv    = 1'b1;
                  res_valid_o = 1'b1;
                  res_o.kind  = KIND_VALUE;
                  res_o.ch    = char_i;
                end
              end
              PH_VALUE: begin
                st_o.fiv    = 1'b1;
                res_valid_o = 1'b1;
                res_o.kind  = KIND_VALUE;
                res_o.ch    = char_i;
              end
              default: begin
                st_o.phase = PH_LINE_START;
              end
            endcase
          end
        end
      end
    end
  end

endmodule

FILE: hw/rtl/properties_text_parser.sv
// Top level of the properties text parser: input register, state and result register.
//
//   Channel | Direction | Payload
//   in_i    | sink      | char_in[15:0], text_end
//   out_o   | source    | kind[2:0], char_out[15:0], text_done
//
// One character request is taken per cycle while the result register can accept it; each gives zero or one result.
// A request passes through the input register, then the result register.
// The single step of parser logic sits between those two registers.
// When the result register is full and not taken, a request in the input register holds and
// in_i.ready falls. Reset (rst_ni low) returns the parser to the start of a line.
module properties_text_parser (
  input  logic      clk_i,
  input  logic      rst_ni,
  ptp_in_if.sink    in_i,
  ptp_out_if.source out_o
);
  import ptp_pkg::*;

  logic        in_valid_q;
  logic [15:0] in_char_q;
  logic        in_end_q;
  state_t      st_q;
  state_t      st_d;
  logic        res_valid;
  result_t     res;
  logic        out_valid_q;
  result_t     out_q;
  logic        out_free;
  logic        adv;

  // The result slot frees when empty or being taken.
  assign out_free = !out_valid_q || out_o.ready;
  assign adv      = in_valid_q && out_free;
  assign in_i.ready = !in_valid_q || out_free;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      in_char_q <= in_i.char_in;
      in_end_q  <= in_i.text_end;
    end
  end

  ptp_step u_step (
    .st_i        (st_q),
    .char_i      (in_char_q),
    .text_end_i  (in_end_q),
    .st_o        (st_d),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // Parser state advances once per processed request.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= STATE_RESET;
    end else if (adv) begin
      st_q <= st_d;
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= adv && res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && res_valid) begin
      out_q <= res;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.kind      = out_q.kind;
  assign out_o.char_out  = out_q.ch;
  assign out_o.text_done = out_q.done;

`ifndef SYNTHESIS
  // End of text always yields a closing result.
  a_end_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && in_end_q |=> out_valid_q && out_q.done)
    else $error("text end did not produce a closing result");

  // End of text returns the parser to the reset state.
  a_end_resets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && in_end_q |=> st_q.phase == PH_LINE_START && !st_q.err && !st_q.esc &&
                        st_q.hex_cnt == 3'd0 && !st_q.fiv)
    else $error("parser state not cleared after text end");

  // A sticky error leaves no escape in progress.
  a_err_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q.err |-> st_q.hex_cnt == 3'd0 && !st_q.esc)
    else $error("escape still pending in error state");

  // At most four hex digits are owed.
  a_hex_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q.hex_cnt <= 3'd4)
    else $error("hex digit count out of range");

  // A final result is never a character.
  a_done_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.done |-> out_q.kind == KIND_END || out_q.kind == KIND_ERROR ||
                                  out_q.kind == KIND_EMPTY)
    else $error("text done flagged on a character result");
`endif

endmodule
